[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication from a trigger to a consequence in the next cycle.
`define CHK_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[rtl/qfx_pkg.sv]
`timescale 1ns / 1ps

package qfx_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 4;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
    localparam logic [OP_W-1:0] OP_MIN  = 4'd4;
    localparam logic [OP_W-1:0] OP_MAX  = 4'd5;
    localparam logic [OP_W-1:0] OP_INC  = 4'd6;
    localparam logic [OP_W-1:0] OP_DEC  = 4'd7;
    localparam logic [OP_W-1:0] OP_FINT = 4'd8;
    localparam logic [OP_W-1:0] OP_TINT = 4'd9;

    // Data that rides along the divider chain next to the quotient state.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [DATA_W-1:0]   res;
        logic                ovf;
        logic                lt;
        logic                eq;
        logic                gt;
        logic                neg;
        logic [2*DATA_W-1:0] prod;
    } t_side;

endpackage

[rtl/qfx_if.sv]
`timescale 1ns / 1ps

interface qfx_in_if;
    logic                                valid;
    logic                                ready;
    logic [qfx_pkg::OP_W-1:0]            op;
    logic signed [qfx_pkg::DATA_W-1:0]   operand_a;
    logic signed [qfx_pkg::DATA_W-1:0]   operand_b;

    modport source (output valid, op, operand_a, operand_b, input ready);
    modport sink (input valid, op, operand_a, operand_b, output ready);
endinterface

interface qfx_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [qfx_pkg::DATA_W-1:0]   result;
    logic                                less_than;
    logic                                equal_to;
    logic                                greater_than;
    logic                                overflow;
    logic                                divide_by_zero;

    modport source (output valid, result, less_than, equal_to, greater_than, overflow,
                    divide_by_zero, input ready);
    modport sink (input valid, result, less_than, equal_to, greater_than, overflow,
                  divide_by_zero, output ready);
endinterface

[rtl/fixed_point_q24_8_alu.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Payload
// i_req     in   valid / ready    op, operand_a, operand_b
// o_rsp     out  valid / ready    result, less_than, equal_to, greater_than,
//                                 overflow, divide_by_zero
//
// One request is taken per cycle unless every stage is full and the result
// waits; each result passes the entry stage, 32 + FRAC_BITS division cells
// and the output stage. The divider chain yields one quotient bit per cell.
// Reset is synchronous and active low; it empties every stage.
// Each stage stalls only when it is full and the stage after it is blocked,
// so bubbles close up and requests keep entering while a result waits.
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = qfx_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qfx_in_if.sink      i_req,
    qfx_out_if.source   o_rsp
);

    localparam int DW    = qfx_pkg::DATA_W;
    localparam int NUM_W = DW + FRAC_BITS;   // numerator width, one cell per bit
    localparam int SW    = 2 * DW;

    localparam logic signed [DW-1:0] RAW_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] RAW_MIN = {1'b1, {(DW-1){1'b0}}};

    // Applies the sign to a magnitude and saturates to the 32-bit range.
    function automatic logic [DW:0] sat_mag(input logic [SW-1:0] mag, input logic neg);
        logic [DW:0] res;
        if (neg) begin
            if (mag > {{(SW-DW-1){1'b0}}, 1'b1, {DW{1'b0}}} >> 1) begin
                res = {1'b1, RAW_MIN};
            end else begin
                res = {1'b0, DW'(~mag[DW-1:0] + 1'b1)};
            end
        end else begin
            if (mag > SW'(RAW_MAX)) begin
                res = {1'b1, RAW_MAX};
            end else begin
                res = {1'b0, mag[DW-1:0]};
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Entry stage: simple operations, compare flags, magnitudes, product.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] w_a;
    logic signed [DW-1:0] w_b;
    logic [DW:0]          w_sum;
    logic [DW:0]          w_dif;
    logic [DW-1:0]        w_mag_a;
    logic [DW-1:0]        w_mag_b;
    logic [FRAC_BITS:0]   w_hi;
    qfx_pkg::t_side       n_side;

    assign w_a     = i_req.operand_a;
    assign w_b     = i_req.operand_b;
    assign w_sum   = {w_a[DW-1], w_a} + {w_b[DW-1], w_b};
    assign w_dif   = {w_a[DW-1], w_a} - {w_b[DW-1], w_b};
    assign w_mag_a = w_a[DW-1] ? DW'(-w_a) : DW'(w_a);
    assign w_mag_b = w_b[DW-1] ? DW'(-w_b) : DW'(w_b);
    assign w_hi    = w_a[DW-1:DW-1-FRAC_BITS];

    always_comb begin
        n_side      = '0;
        n_side.op   = i_req.op;
        n_side.lt   = w_a < w_b;
        n_side.eq   = w_a == w_b;
        n_side.gt   = w_a > w_b;
        n_side.neg  = w_a[DW-1] ^ w_b[DW-1];
        n_side.prod = SW'(w_mag_a) * SW'(w_mag_b);
        unique case (i_req.op)
            qfx_pkg::OP_ADD: begin
                n_side.ovf = w_sum[DW] != w_sum[DW-1];
                n_side.res = n_side.ovf ? (w_sum[DW] ? RAW_MIN : RAW_MAX) : w_sum[DW-1:0];
            end
            qfx_pkg::OP_SUB: begin
                n_side.ovf = w_dif[DW] != w_dif[DW-1];
                n_side.res = n_side.ovf ? (w_dif[DW] ? RAW_MIN : RAW_MAX) : w_dif[DW-1:0];
            end
            qfx_pkg::OP_MIN: n_side.res = (w_a < w_b) ? w_a : w_b;
            qfx_pkg::OP_MAX: n_side.res = (w_a > w_b) ? w_a : w_b;
            qfx_pkg::OP_INC: begin
                n_side.ovf = w_a == RAW_MAX;
                n_side.res = n_side.ovf ? RAW_MAX : w_a + 1'b1;
            end
            qfx_pkg::OP_DEC: begin
                n_side.ovf = w_a == RAW_MIN;
                n_side.res = n_side.ovf ? RAW_MIN : w_a - 1'b1;
            end
            qfx_pkg::OP_FINT: begin
                n_side.ovf = !((&w_hi) || !(|w_hi));
                n_side.res = n_side.ovf ? (w_a[DW-1] ? RAW_MIN : RAW_MAX) : (w_a <<< FRAC_BITS);
            end
            qfx_pkg::OP_TINT: n_side.res = w_a >>> FRAC_BITS;
            default: n_side.res = '0;
        endcase
    end

    logic                    r_v0;
    logic [DW+NUM_W-1:0]     r_rq0;
    logic [DW-1:0]           r_den0;
    qfx_pkg::t_side          r_side0;

    logic [NUM_W:0]          w_v;
    logic [NUM_W:0]          w_rdy;
    logic [DW+NUM_W-1:0]     w_rq   [NUM_W+1];
    logic [DW-1:0]           w_den  [NUM_W+1];
    qfx_pkg::t_side          w_side [NUM_W+1];

    assign i_req.ready = !r_v0 || w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_req.ready) begin
            r_v0 <= i_req.valid;
        end
        if (i_req.ready && i_req.valid) begin
            r_rq0   <= {{DW{1'b0}}, w_mag_a, {FRAC_BITS{1'b0}}};
            r_den0  <= w_mag_b;
            r_side0 <= n_side;
        end
    end

    assign w_v[0]    = r_v0;
    assign w_rq[0]   = r_rq0;
    assign w_den[0]  = r_den0;
    assign w_side[0] = r_side0;

    // ------------------------------------------------------------------
    // Divider chain: cell k produces quotient bit NUM_W-1-k.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NUM_W; k++) begin : g_cell
        qfx_div_cell #(
            .NUM_W (NUM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_rq    (w_rq[k]),
            .i_den   (w_den[k]),
            .i_side  (w_side[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_rq    (w_rq[k+1]),
            .o_den   (w_den[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: rounding and saturation of product and quotient.
    // ------------------------------------------------------------------
    qfx_pkg::t_side          w_fs;
    logic [NUM_W-1:0]        w_quo;
    logic [DW-1:0]           w_rem;
    logic [SW-1:0]           w_qr;
    logic [SW-1:0]           w_mr;
    logic [DW:0]             w_qsat;
    logic [DW:0]             w_msat;
    logic                    w_dz;
    logic signed [DW-1:0]    n_res;
    logic                    n_ovf;

    assign w_fs   = w_side[NUM_W];
    assign w_quo  = w_rq[NUM_W][NUM_W-1:0];
    assign w_rem  = w_rq[NUM_W][DW+NUM_W-1:NUM_W];
    assign w_qr   = SW'(w_quo) + SW'({w_rem, 1'b0} >= {1'b0, w_den[NUM_W]});
    assign w_mr   = (w_fs.prod + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign w_qsat = sat_mag(w_qr, w_fs.neg);
    assign w_msat = sat_mag(w_mr, w_fs.neg);
    assign w_dz   = (w_fs.op == qfx_pkg::OP_DIV) && (w_den[NUM_W] == '0);

    always_comb begin
        if (w_fs.op == qfx_pkg::OP_MUL) begin
            n_res = w_msat[DW-1:0];
            n_ovf = w_msat[DW];
        end else if (w_fs.op == qfx_pkg::OP_DIV) begin
            n_res = w_dz ? '0 : w_qsat[DW-1:0];
            n_ovf = !w_dz && w_qsat[DW];
        end else begin
            n_res = w_fs.res;
            n_ovf = w_fs.ovf;
        end
    end

    logic r_ov;

    assign w_rdy[NUM_W] = !r_ov || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_rdy[NUM_W]) begin
            r_ov <= w_v[NUM_W];
        end
        if (w_rdy[NUM_W] && w_v[NUM_W]) begin
            o_rsp.result         <= n_res;
            o_rsp.less_than      <= w_fs.lt;
            o_rsp.equal_to       <= w_fs.eq;
            o_rsp.greater_than   <= w_fs.gt;
            o_rsp.overflow       <= n_ovf;
            o_rsp.divide_by_zero <= w_dz;
        end
    end

    assign o_rsp.valid = r_ov;

endmodule

[rtl/qfx_div_cell.sv]
`timescale 1ns / 1ps

// One restoring division step: shifts a numerator bit into the partial
// remainder, subtracts the divisor when it fits and records the quotient bit.
module qfx_div_cell #(
    parameter int NUM_W = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [qfx_pkg::DATA_W+NUM_W-1:0]  i_rq,
    input  logic [qfx_pkg::DATA_W-1:0]        i_den,
    input  qfx_pkg::t_side                    i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [qfx_pkg::DATA_W+NUM_W-1:0]  o_rq,
    output logic [qfx_pkg::DATA_W-1:0]        o_den,
    output qfx_pkg::t_side                    o_side
);

    localparam int RW = qfx_pkg::DATA_W;

    logic                             r_v;
    logic [RW+NUM_W-1:0]              r_rq;
    logic [RW-1:0]                    r_den;
    qfx_pkg::t_side                   r_side;
    logic [RW:0]                      w_t;
    logic [RW:0]                      w_diff;
    logic                             w_ge;
    logic [RW+NUM_W-1:0]              n_rq;

    assign o_ready = !r_v || i_ready;
    // The shifted remainder needs one bit more than the remainder field.
    assign w_t     = {i_rq[RW+NUM_W-1:NUM_W], i_rq[NUM_W-1]};
    assign w_diff  = w_t - {1'b0, i_den};
    assign w_ge    = w_t >= {1'b0, i_den};
    assign n_rq    = {(w_ge ? w_diff[RW-1:0] : w_t[RW-1:0]), i_rq[NUM_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_rq   <= n_rq;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_rq    = r_rq;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

[rtl/qfx_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qfx_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              i_ready,
    input logic signed [qfx_pkg::DATA_W-1:0] i_result,
    input logic                              i_lt,
    input logic                              i_eq,
    input logic                              i_gt,
    input logic                              i_ovf,
    input logic                              i_dz
);

    // A zero divisor always gives a clean zero without overflow.
    `CHK_ALWAYS(a_dz_zero, i_clk, i_rst_n, !(i_valid && i_dz) || (i_result == '0 && !i_ovf), "dz result not zero")
    // Exactly one compare flag describes the operand pair.
    `CHK_ALWAYS(a_cmp_onehot, i_clk, i_rst_n, !i_valid || $onehot({i_lt, i_eq, i_gt}), "compare flags not one-hot")
    // A saturated result sits at one end of the range.
    `CHK_ALWAYS(a_ovf_end, i_clk, i_rst_n, !(i_valid && i_ovf) || i_result == {1'b0, {(qfx_pkg::DATA_W-1){1'b1}}} || i_result == {1'b1, {(qfx_pkg::DATA_W-1){1'b0}}}, "overflow value off range end")
    // A stalled response stays offered.
    `CHK_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_result), "stalled response dropped")

endmodule

bind fixed_point_q24_8_alu qfx_checker u_qfx_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_rsp.valid),
    .i_ready  (o_rsp.ready),
    .i_result (o_rsp.result),
    .i_lt     (o_rsp.less_than),
    .i_eq     (o_rsp.equal_to),
    .i_gt     (o_rsp.greater_than),
    .i_ovf    (o_rsp.overflow),
    .i_dz     (o_rsp.divide_by_zero)
);
